// File: src/bptc_pkg.sv
package bptc_pkg;

	localparam int OSS_DEFAULT = 0;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_AC1     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC2     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC3     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AC4     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd7;

	localparam int UT_W = 16;
	localparam int UP_W = 19;
	localparam int T_W  = 16;
	localparam int P_W  = 20;

	localparam int T_QW = 27;
	localparam int P_QW = 32;
	localparam int LATENCY = 5 + T_QW + 14 + P_QW;

	localparam int C_B6_OFS  = 4000;
	localparam int C_K_OFS   = 32768;
	localparam int C_B7_MUL  = 50000;
	localparam int C_PA      = 3038;
	localparam int C_PB      = -7357;
	localparam int C_PC      = 3791;
	localparam int C_P_MAX   = 1048575;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
	} coef_t;

	typedef struct packed {
		logic               valid;
		logic               fault;
		logic signed [T_W-1:0] t;
		logic signed [31:0] b6;
		logic [UP_W-1:0]    up;
	} tp_t;

	typedef struct packed {
		logic               valid;
		logic               fault;
		logic signed [T_W-1:0] t;
		logic [P_W-1:0]     p;
	} res_t;

	function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
		input int unsigned k);
		logic signed [31:0] bias;
		bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
		return (x + bias) >>> k;
	endfunction

endpackage

// File: src/barometer_temp_pressure_compensation.sv
// Channel   Handshake         Payload
// command   start / busy      raw_temperature, raw_pressure
// result    done (strobe)     temperature_tenths, pressure_pa, divide_fault
// config    cfg_we            cfg_index, cfg_wdata
//
// One command beat per cycle; busy stays low.
// Each result passes through two bit-serial
// divider pipelines (27 and 32 stages) plus the multiply and adjust stages.
// arst_n clears all valid bits and the coefficients to zero.
// done lasts one cycle; results are never held back.
module barometer_temp_pressure_compensation #(
	parameter int unsigned OVERSAMPLING = bptc_pkg::OSS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bptc_pkg::UT_W-1:0]       raw_temperature,
	input  logic [bptc_pkg::UP_W-1:0]       raw_pressure,
	input  logic                            cfg_we,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                            done,
	output logic signed [bptc_pkg::T_W-1:0] temperature_tenths,
	output logic [bptc_pkg::P_W-1:0]        pressure_pa,
	output logic                            divide_fault
);
	import bptc_pkg::*;

	coef_t coef_q;
	tp_t   tp;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1:     coef_q.ac1 <= cfg_wdata[15:0];
				REG_AC2:     coef_q.ac2 <= cfg_wdata[15:0];
				REG_AC3:     coef_q.ac3 <= cfg_wdata[15:0];
				REG_AC4:     coef_q.ac4 <= cfg_wdata[15:0];
				REG_AC5_AC6: begin
					coef_q.ac5 <= cfg_wdata[31:16];
					coef_q.ac6 <= cfg_wdata[15:0];
				end
				REG_B1:      coef_q.b1 <= cfg_wdata[15:0];
				REG_B2:      coef_q.b2 <= cfg_wdata[15:0];
				REG_MC_MD:   begin
					coef_q.mc <= cfg_wdata[31:16];
					coef_q.md <= cfg_wdata[15:0];
				end
				default:     coef_q <= coef_q;
			endcase
		end
	end

	assign busy = 1'b0;

	bptc_temp u_temp (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef_q),
		.in_valid(start && !busy),
		.ut      (raw_temperature),
		.up      (raw_pressure),
		.tp      (tp)
	);

	bptc_press #(
		.OVERSAMPLING(OVERSAMPLING)
	) u_press (
		.clk   (clk),
		.arst_n(arst_n),
		.coef  (coef_q),
		.tp    (tp),
		.res   (res)
	);

	assign done               = res.valid;
	assign divide_fault       = res.fault;
	assign temperature_tenths = res.t;
	assign pressure_pa        = res.p;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_fault) |-> (temperature_tenths == '0 && pressure_pa == '0))
		else $error("fault beat carries nonzero result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("command beat produced no result");

endmodule

// File: src/bptc_div.sv
module bptc_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [NW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);

	logic          v_s   [1:NW];
	logic [NW-1:0] num_s [1:NW];
	logic [NW-1:0] quo_s [1:NW];
	logic [DW-1:0] rem_s [1:NW];
	logic [DW-1:0] den_s [1:NW];
	logic [TW-1:0] tag_s [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          v_i;
		logic [NW-1:0] n_i;
		logic [NW-1:0] q_i;
		logic [DW-1:0] r_i;
		logic [DW-1:0] d_i;
		logic [TW-1:0] t_i;
		logic [DW+1:0] trial;
		logic [DW+1:0] diff;
		logic          take;

		if (k == 0) begin : g_head
			assign v_i = in_valid;
			assign n_i = in_num;
			assign q_i = '0;
			assign r_i = '0;
			assign d_i = in_den;
			assign t_i = in_tag;
		end else begin : g_body
			assign v_i = v_s[k];
			assign n_i = num_s[k];
			assign q_i = quo_s[k];
			assign r_i = rem_s[k];
			assign d_i = den_s[k];
			assign t_i = tag_s[k];
		end

		assign trial = {1'b0, r_i, n_i[NW-1]};
		assign diff  = trial - {2'b00, d_i};
		assign take  = !diff[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1] <= n_i << 1;
			quo_s[k+1] <= {q_i[NW-2:0], take};
			rem_s[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k+1] <= d_i;
			tag_s[k+1] <= t_i;
		end
	end

	assign out_valid = v_s[NW];
	assign out_quo   = quo_s[NW];
	assign out_tag   = tag_s[NW];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##NW out_valid)
		else $error("divider beat lost");

	a_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[NW] && den_s[NW] != '0) |-> (rem_s[NW] < den_s[NW]))
		else $error("divider remainder not below divisor");

endmodule

// File: src/bptc_temp.sv
module bptc_temp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bptc_pkg::coef_t              coef,
	input  logic                         in_valid,
	input  logic [bptc_pkg::UT_W-1:0]    ut,
	input  logic [bptc_pkg::UP_W-1:0]    up,
	output bptc_pkg::tp_t                tp
);
	import bptc_pkg::*;

	localparam int TAG_W = 32 + UP_W + 2;

	logic signed [16:0] diff;
	logic signed [33:0] prod;

	logic                 v_s1;
	logic signed [31:0]   prod_s1;
	logic [UP_W-1:0]      up_s1;

	logic signed [31:0]   x1;
	logic                 v_s2;
	logic signed [31:0]   x1_s2;
	logic signed [31:0]   den_s2;
	logic [UP_W-1:0]      up_s2;

	logic [31:0]          num;
	logic [31:0]          num_abs;
	logic [31:0]          den_abs;
	logic                 v_s3;
	logic [T_QW-1:0]      nmag_s3;
	logic [31:0]          dmag_s3;
	logic                 neg_s3;
	logic                 fault_s3;
	logic signed [31:0]   x1_s3;
	logic [UP_W-1:0]      up_s3;

	logic                 dv;
	logic [T_QW-1:0]      dq;
	logic [TAG_W-1:0]     dtag;
	logic signed [31:0]   dx1;
	logic [UP_W-1:0]      dup;
	logic                 dneg;
	logic                 dfault;
	logic signed [31:0]   q32;
	logic signed [31:0]   x2;

	logic                 v_s4;
	logic signed [31:0]   b5_s4;
	logic [UP_W-1:0]      up_s4;
	logic                 fault_s4;

	logic signed [31:0]   t32;
	logic signed [T_W-1:0] tsat;
	logic                 v_s5;
	logic                 fault_s5;
	logic signed [T_W-1:0] t_s5;
	logic signed [31:0]   b6_s5;
	logic [UP_W-1:0]      up_s5;

	assign diff = $signed({1'b0, ut}) - $signed({1'b0, coef.ac6});
	assign prod = diff * $signed({1'b0, coef.ac5});

	assign x1 = sdiv_p2(prod_s1, 15);

	assign num     = {{5{coef.mc[15]}}, coef.mc, 11'b0};
	assign num_abs = num[31] ? (~num + 32'd1) : num;
	assign den_abs = den_s2[31] ? (~den_s2 + 32'd1) : den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod[31:0];
		up_s1    <= up;
		x1_s2    <= x1;
		den_s2   <= x1 + 32'(coef.md);
		up_s2    <= up_s1;
		nmag_s3  <= num_abs[T_QW-1:0];
		dmag_s3  <= den_abs;
		neg_s3   <= num[31] ^ den_s2[31];
		fault_s3 <= (den_s2 == 32'sd0);
		x1_s3    <= x1_s2;
		up_s3    <= up_s2;
	end

	bptc_div #(
		.NW(T_QW),
		.DW(32),
		.TW(TAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_num   (nmag_s3),
		.in_den   (dmag_s3),
		.in_tag   ({x1_s3, up_s3, neg_s3, fault_s3}),
		.out_valid(dv),
		.out_quo  (dq),
		.out_tag  (dtag)
	);

	assign {dx1, dup, dneg, dfault} = dtag;
	assign q32 = $signed({{(32-T_QW){1'b0}}, dq});
	assign x2  = dneg ? -q32 : q32;

	always_ff @(posedge clk) begin
		b5_s4    <= dx1 + x2;
		up_s4    <= dup;
		fault_s4 <= dfault;
	end

	always_comb begin
		t32 = sdiv_p2(b5_s4 + 32'sd8, 4);
		if (t32 > 32'sd32767) begin
			tsat = 16'sh7FFF;
		end else if (t32 < -32'sd32768) begin
			tsat = 16'sh8000;
		end else begin
			tsat = t32[T_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		fault_s5 <= fault_s4;
		t_s5     <= tsat;
		b6_s5    <= b5_s4 - 32'(C_B6_OFS);
		up_s5    <= up_s4;
	end

	always_comb begin
		tp.valid = v_s5;
		tp.fault = fault_s5;
		tp.t     = t_s5;
		tp.b6    = b6_s5;
		tp.up    = up_s5;
	end

endmodule

// File: src/bptc_press.sv
module bptc_press #(
	parameter int unsigned OVERSAMPLING = bptc_pkg::OSS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bptc_pkg::coef_t coef,
	input  bptc_pkg::tp_t   tp,
	output bptc_pkg::res_t  res
);
	import bptc_pkg::*;

	localparam logic [1:0]  OSS     = 2'(OVERSAMPLING);
	localparam logic [15:0] B7_MUL  = 16'(C_B7_MUL >> OSS);
	localparam int          TAG_W   = T_W + 2;
	localparam logic signed [15:0] PA = 16'(C_PA);
	localparam logic signed [15:0] PB = 16'(C_PB);

	logic [7:0] v_s;

	logic signed [47:0] mac2;
	logic signed [47:0] mac3;
	logic signed [31:0] sqp;
	logic signed [31:0] sqp_s1, mac2_s1, mac3_s1;
	logic signed [31:0] sq_s2, x2a_s2, x1c_s2;
	logic signed [47:0] mb2, mb1;
	logic signed [31:0] mb2_s3, mb1_s3, x2a_s3, x1c_s3;
	logic signed [31:0] x1a_s4, x2c_s4, x2a_s4, x1c_s4;
	logic signed [31:0] x3_s5, sc_s5;
	logic signed [31:0] a1, b3;
	logic signed [31:0] b3_s6;
	logic [31:0]        k_s6;
	logic [47:0]        b4p;
	logic [31:0]        b4_s7, bm_s7;
	logic [47:0]        b7p;
	logic [31:0]        b7_s8, b4_s8;
	logic               fault_s8;

	logic [UP_W-1:0]     up_c [1:7];
	logic signed [T_W-1:0] t_c [1:8];
	logic               f_c [1:7];

	logic               dv;
	logic [P_QW-1:0]    dq;
	logic [TAG_W-1:0]   dtag;
	logic signed [T_W-1:0] dt;
	logic               dfault;
	logic               dhi;

	logic [4:0]         w_s;
	logic signed [31:0] p_s9, p_s10, p_s11, p_s12, p_s13;
	logic signed [31:0] pd_s10, m7_s10;
	logic signed [47:0] m7;
	logic signed [31:0] sqq_s11, x2_s11, x2_s12;
	logic signed [47:0] m3;
	logic signed [31:0] m3_s12, x3s_s13;
	logic signed [T_W-1:0] t_w [9:13];
	logic               f_w [9:13];

	logic signed [31:0] x3f, pf;
	logic [P_W-1:0]     psat;
	logic               v_s14;
	logic               fault_s14;
	logic signed [T_W-1:0] t_s14;
	logic [P_W-1:0]     p_s14;

	assign sqp  = tp.b6 * tp.b6;
	assign mac2 = coef.ac2 * tp.b6;
	assign mac3 = coef.ac3 * tp.b6;
	assign mb2  = coef.b2 * sq_s2;
	assign mb1  = coef.b1 * sq_s2;
	assign a1   = ($signed(32'(coef.ac1)) <<< 2) + x3_s5;
	assign b3   = sdiv_p2((a1 <<< OSS) + 32'sd2, 2);
	assign b4p  = coef.ac4 * k_s6;
	assign b7p  = bm_s7 * B7_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[6:0], tp.valid};
		end
	end

	always_ff @(posedge clk) begin
		sqp_s1  <= sqp;
		mac2_s1 <= mac2[31:0];
		mac3_s1 <= mac3[31:0];
		up_c[1] <= tp.up;
		t_c[1]  <= tp.t;
		f_c[1]  <= tp.fault;

		sq_s2   <= sdiv_p2(sqp_s1, 12);
		x2a_s2  <= sdiv_p2(mac2_s1, 11);
		x1c_s2  <= sdiv_p2(mac3_s1, 13);

		mb2_s3  <= mb2[31:0];
		mb1_s3  <= mb1[31:0];
		x2a_s3  <= x2a_s2;
		x1c_s3  <= x1c_s2;

		x1a_s4  <= sdiv_p2(mb2_s3, 11);
		x2c_s4  <= sdiv_p2(mb1_s3, 16);
		x2a_s4  <= x2a_s3;
		x1c_s4  <= x1c_s3;

		x3_s5   <= x1a_s4 + x2a_s4;
		sc_s5   <= x1c_s4 + x2c_s4 + 32'sd2;

		b3_s6   <= b3;
		k_s6    <= sdiv_p2(sc_s5, 2) + 32'(C_K_OFS);

		b4_s7   <= {15'd0, b4p[31:15]};
		bm_s7   <= {{(32-UP_W){1'b0}}, up_c[6]} - b3_s6;

		b7_s8    <= b7p[31:0];
		b4_s8    <= b4_s7;
		fault_s8 <= f_c[7] || (b4_s7 == 32'd0);
		t_c[8]   <= t_c[7];

		for (int i = 2; i <= 7; i++) begin
			up_c[i] <= up_c[i-1];
			t_c[i]  <= t_c[i-1];
			f_c[i]  <= f_c[i-1];
		end
	end

	bptc_div #(
		.NW(P_QW),
		.DW(32),
		.TW(TAG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s[7]),
		.in_num   (b7_s8[31] ? b7_s8 : {b7_s8[30:0], 1'b0}),
		.in_den   (b4_s8),
		.in_tag   ({t_c[8], fault_s8, b7_s8[31]}),
		.out_valid(dv),
		.out_quo  (dq),
		.out_tag  (dtag)
	);

	assign {dt, dfault, dhi} = dtag;
	assign m7 = PB * p_s9;
	assign m3 = PA * sqq_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_s   <= '0;
			v_s14 <= 1'b0;
		end else begin
			w_s   <= {w_s[3:0], dv};
			v_s14 <= w_s[4];
		end
	end

	always_ff @(posedge clk) begin
		p_s9    <= dhi ? $signed({dq[30:0], 1'b0}) : $signed(dq);
		t_w[9]  <= dt;
		f_w[9]  <= dfault;

		pd_s10  <= sdiv_p2(p_s9, 8);
		m7_s10  <= m7[31:0];
		p_s10   <= p_s9;

		sqq_s11 <= pd_s10 * pd_s10;
		x2_s11  <= sdiv_p2(m7_s10, 16);
		p_s11   <= p_s10;

		m3_s12  <= m3[31:0];
		x2_s12  <= x2_s11;
		p_s12   <= p_s11;

		x3s_s13 <= sdiv_p2(m3_s12, 16) + x2_s12 + 32'(C_PC);
		p_s13   <= p_s12;

		for (int i = 10; i <= 13; i++) begin
			t_w[i] <= t_w[i-1];
			f_w[i] <= f_w[i-1];
		end
	end

	always_comb begin
		x3f = sdiv_p2(x3s_s13, 4);
		pf  = p_s13 + x3f;
		if (pf < 32'sd0) begin
			psat = '0;
		end else if (pf > 32'(C_P_MAX)) begin
			psat = P_W'(C_P_MAX);
		end else begin
			psat = pf[P_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		fault_s14 <= f_w[13];
		t_s14     <= f_w[13] ? '0 : t_w[13];
		p_s14     <= f_w[13] ? '0 : psat;
	end

	always_comb begin
		res.valid = v_s14;
		res.fault = fault_s14;
		res.t     = t_s14;
		res.p     = p_s14;
	end

endmodule

// File: verif/barometer_temp_pressure_compensation_test.sv
`timescale 1ns / 100ps

module barometer_temp_pressure_compensation_test;
	import bptc_pkg::*;

	typedef struct {
		logic signed [T_W-1:0] t;
		logic [P_W-1:0]        p;
		logic                  fault;
	} reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [UT_W-1:0]       raw_temperature;
	logic [UP_W-1:0]       raw_pressure;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  done;
	logic signed [T_W-1:0] temperature_tenths;
	logic [P_W-1:0]        pressure_pa;
	logic                  divide_fault;

	logic [31:0] coef_mirror [8];
	reading_t    pending_readings [$];
	int          mismatches;
	int          idle_pct;

	barometer_temp_pressure_compensation DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .temperature_tenths(temperature_tenths),
		.pressure_pa(pressure_pa), .divide_fault(divide_fault)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint wrap32(input longint x);
		return longint'($signed(x[31:0]));
	endfunction

	function automatic longint sext16(input logic [15:0] x);
		return longint'($signed(x));
	endfunction

	function automatic reading_t compensate(input logic [UT_W-1:0] ut_in,
		input logic [UP_W-1:0] up_in);
		reading_t r;
		int unsigned oss;
		longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
		longint x1, x2, x3, den, b5, b6, b3, sq, t, p;
		longint unsigned prod;
		logic [31:0] ac4, b4, b7, q, tmp;
		oss = OSS_DEFAULT & 3;
		ac1 = sext16(coef_mirror[REG_AC1][15:0]);
		ac2 = sext16(coef_mirror[REG_AC2][15:0]);
		ac3 = sext16(coef_mirror[REG_AC3][15:0]);
		ac4 = {16'd0, coef_mirror[REG_AC4][15:0]};
		ac5 = longint'(coef_mirror[REG_AC5_AC6][31:16]);
		ac6 = longint'(coef_mirror[REG_AC5_AC6][15:0]);
		b1 = sext16(coef_mirror[REG_B1][15:0]);
		b2 = sext16(coef_mirror[REG_B2][15:0]);
		mc = sext16(coef_mirror[REG_MC_MD][31:16]);
		md = sext16(coef_mirror[REG_MC_MD][15:0]);
		ut = longint'(ut_in);
		up = longint'(up_in);
		r.t = '0;
		r.p = '0;
		r.fault = 1'b1;
		x1 = wrap32((ut - ac6) * ac5) / 32768;
		den = wrap32(x1 + md);
		if (den == 0) return r;
		x2 = wrap32(mc * 2048) / den;
		b5 = wrap32(x1 + x2);
		t = wrap32(b5 + 8) / 16;
		b6 = wrap32(b5 - C_B6_OFS);
		sq = wrap32(b6 * b6) / 4096;
		x1 = wrap32(b2 * sq) / 2048;
		x2 = wrap32(ac2 * b6) / 2048;
		x3 = wrap32(x1 + x2);
		b3 = wrap32(wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << oss)) + 2) / 4;
		x1 = wrap32(ac3 * b6) / 8192;
		x2 = wrap32(b1 * sq) / 65536;
		x3 = wrap32(wrap32(x1 + x2) + 2) / 4;
		tmp = 32'(x3 + C_K_OFS);
		prod = longint'(ac4) * longint'(tmp);
		b4 = prod[31:0] >> 15;
		if (b4 == 0) return r;
		tmp = 32'(up) - 32'(b3);
		b7 = tmp * (32'(C_B7_MUL) >> oss);
		if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
		else q = (b7 / b4) * 32'd2;
		p = wrap32(longint'(q));
		x1 = p / 256;
		x1 = wrap32(x1 * x1);
		x1 = wrap32(x1 * C_PA) / 65536;
		x2 = wrap32(C_PB * p) / 65536;
		x3 = wrap32(wrap32(x1 + x2) + C_PC) / 16;
		p = wrap32(p + x3);
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		if (p < 0) p = 0;
		if (p > C_P_MAX) p = C_P_MAX;
		r.t = T_W'(t);
		r.p = P_W'(p);
		r.fault = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat t=%0d p=%0d f=%0b",
						temperature_tenths, pressure_pa, divide_fault);
			end else begin
				want = pending_readings.pop_front();
				if (want.t !== temperature_tenths || want.p !== pressure_pa ||
					want.fault !== divide_fault) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected t=%0d p=%0d f=%0b, got t=%0d p=%0d f=%0b",
							want.t, want.p, want.fault,
							temperature_tenths, pressure_pa, divide_fault);
				end
			end
		end
	end

	task automatic send_reading(input logic [UT_W-1:0] ut, input logic [UP_W-1:0] up);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		raw_temperature <= ut;
		raw_pressure <= up;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_readings.push_back(compensate(ut, up));
	endtask

	task automatic drain();
		start <= 1'b0;
		wait (pending_readings.size() == 0);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_coefs(input logic [31:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= vals[i];
			coef_mirror[i] = (i == REG_AC5_AC6 || i == REG_MC_MD) ? vals[i]
				: {16'd0, vals[i][15:0]};
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void datasheet_coefs(output logic [31:0] v [8]);
		v[REG_AC1] = 32'(408);
		v[REG_AC2] = 32'(-72);
		v[REG_AC3] = 32'(-14383);
		v[REG_AC4] = 32'd32741;
		v[REG_AC5_AC6] = {16'd32757, 16'd23153};
		v[REG_B1] = 32'd6190;
		v[REG_B2] = 32'd4;
		v[REG_MC_MD] = {16'(-8711), 16'd2868};
	endfunction

	task automatic test_reset_fault();
		send_reading(16'd27898, 19'd23843);
		send_reading('1, '1);
		send_reading('0, '0);
		drain();
	endtask

	task automatic test_datasheet();
		logic [31:0] v [8];
		datasheet_coefs(v);
		load_coefs(v);
		send_reading(16'd27898, 19'd23843);
		send_reading('0, '0);
		send_reading('1, '1);
		send_reading(16'h8000, 19'h40000);
		send_reading(16'd23153, 19'd1);
		drain();
	endtask

	task automatic test_divide_faults();
		logic [31:0] v [8];
		datasheet_coefs(v);
		v[REG_AC4] = 32'd0;
		load_coefs(v);
		send_reading(16'd27898, 19'd23843);
		send_reading(16'd1000, 19'd60000);
		drain();
		datasheet_coefs(v);
		v[REG_AC5_AC6] = {16'd0, 16'd23153};
		v[REG_MC_MD] = {16'(-8711), 16'd0};
		load_coefs(v);
		send_reading(16'd27898, 19'd23843);
		send_reading('1, '1);
		drain();
	endtask

	task automatic test_extreme_coefs();
		logic [31:0] v [8];
		logic [31:0] pats [3];
		pats[0] = 32'hFFFF_FFFF;
		pats[1] = 32'h8000_8000;
		pats[2] = 32'h7FFF_7FFF;
		foreach (pats[k]) begin
			for (int i = 0; i < 8; i++) v[i] = pats[k];
			load_coefs(v);
			send_reading('0, '0);
			send_reading('1, '1);
			send_reading(16'h5555, 19'h2AAAA);
			drain();
		end
	endtask

	task automatic test_random(input int n_sets, input int per_set);
		logic [31:0] v [8];
		for (int s = 0; s < n_sets; s++) begin
			if ($urandom_range(2) == 0) begin
				for (int i = 0; i < 8; i++) v[i] = $urandom;
			end else begin
				datasheet_coefs(v);
				for (int i = 0; i < 8; i++)
					v[i] = v[i] + 32'($signed($urandom_range(400)) - 200);
			end
			load_coefs(v);
			for (int n = 0; n < per_set; n++) begin
				if ($urandom_range(3) == 0)
					send_reading(16'($urandom), 19'($urandom));
				else
					send_reading(16'($urandom_range(32000, 24000)),
						19'($urandom_range(45000, 15000)));
			end
			drain();
		end
	endtask

	initial begin
		mismatches = 0;
		idle_pct = 24;
		for (int i = 0; i < 8; i++) coef_mirror[i] = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		raw_temperature <= '0;
		raw_pressure <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_fault();
		test_datasheet();
		test_divide_faults();
		test_extreme_coefs();
		idle_pct = 24;
		test_random(5, 100);
		idle_pct = 65;
		test_random(4, 100);
		idle_pct = 0;
		test_random(5, 100);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && pending_readings.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
src/bptc_pkg.sv
src/bptc_div.sv
src/bptc_temp.sv
src/bptc_press.sv
src/barometer_temp_pressure_compensation.sv
verif/barometer_temp_pressure_compensation_test.sv
